// ----- design/dgcd_pkg.sv -----
// ----------------------------------------------------------------------------
// dgcd_pkg: shared types for the directed graph cycle detector
// Datapath command codes and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package dgcd_pkg;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR,
    DP_ADD_RD,
    DP_ADD_WR,
    DP_DROP,
    DP_CHK_INIT,
    DP_START_RD,
    DP_START_PUSH,
    DP_NEXT_SRC,
    DP_PUSH_LD,
    DP_POP,
    DP_POP_LD,
    DP_EDGE_RD,
    DP_EDGE_LD,
    DP_EDGE_PUSH,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    logic clr_last;
    logic edge_ok;
    logic src_done;
    logic visited_q;
    logic onstk_q;
    logic cur_zero;
    logic depth_one;
    logic dropped;
  } sts_t;

endpackage

// ----- design/directed_graph_cycle_detect_core.sv -----
// Edge load: list head read, then pool and head write per beat; a dropped edge skips both.
// Check: a depth-first walk from each unvisited in-use vertex runs from the check beat to
// the result register; a back edge ends the walk early and a result still held on the
// output delays the next one.
// After each result and after reset a clearing sweep over all MAX_VERTICES entries resets
// list heads and marks; input is stalled during it. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
// directed_graph_cycle_detect_core: directed graph cycle detector top level
// Loads edges into adjacency lists and runs a depth-first cycle check.
// ----------------------------------------------------------------------------
module directed_graph_cycle_detect_core #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [9:0]  in_source_vertex,
  input  logic [9:0]  in_target_vertex,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_cycle,
  output logic        out_input_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_vertex_count
);

  dgcd_pkg::dp_op_t op;
  dgcd_pkg::sts_t   sts;

  assign cfg_ready = 1'b1;

  dgcd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_op           (in_op),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_has_cycle   (out_has_cycle),
    .out_input_error (out_input_error),
    .sts             (sts),
    .op              (op)
  );

  dgcd_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_source_vertex (in_source_vertex),
    .in_target_vertex (in_target_vertex),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_vertex_count (cfg_vertex_count),
    .sts              (sts)
  );

endmodule

// ----- design/dgcd_dp.sv -----
// ----------------------------------------------------------------------------
// dgcd_dp: graph storage and depth-first walk datapath
// Edge pool, list heads, marks, walk stack and the walk registers.
// ----------------------------------------------------------------------------
module dgcd_dp #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dgcd_pkg::dp_op_t    op,
  input  logic [9:0]          in_source_vertex,
  input  logic [9:0]          in_target_vertex,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [10:0]         cfg_vertex_count,
  output dgcd_pkg::sts_t      sts
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int DW  = $clog2(MAX_VERTICES + 1);
  localparam int CW  = (DW > 11) ? DW : 11;
  localparam int SW  = VW + EW;

  // memories
  logic [EW-1:0] head_mem [MAX_VERTICES];
  logic          vis_mem  [MAX_VERTICES];
  logic          on_mem   [MAX_VERTICES];
  logic [VW-1:0] etgt_mem [MAX_EDGES];
  logic [EW-1:0] enxt_mem [MAX_EDGES];
  logic [SW-1:0] stk_mem  [MAX_VERTICES];

  logic [EW-1:0] head_q;
  logic          vis_q, on_q;
  logic [VW-1:0] etgt_q;
  logic [EW-1:0] enxt_q;
  logic [SW-1:0] stk_q;

  logic [10:0]   vcount_r;
  logic [EW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic [VW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [VW-1:0] top_v_r, top_v_nxt;
  logic [EW-1:0] top_cur_r, top_cur_nxt;
  logic [VW-1:0] src_r, src_nxt;
  logic [VW-1:0] dst_r, dst_nxt;
  logic [VW-1:0] t_r, t_nxt;

  logic [CW-1:0] n_eff;

  // port controls
  logic          head_we, vis_we, on_we, pool_we, stk_we;
  logic [VW-1:0] head_wa, head_ra, vis_wa, vis_ra, on_wa, on_ra, stk_wa, stk_ra;
  logic [EW-1:0] head_wd;
  logic          vis_wd, on_wd;
  logic [EIW-1:0] pool_wa, pool_ra;

  assign n_eff = (CW'(vcount_r) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_r);

  assign sts.clr_last  = (clr_r == VW'(MAX_VERTICES - 1));
  assign sts.edge_ok   = (CW'(in_source_vertex) < n_eff) && (CW'(in_target_vertex) < n_eff)
                         && (cnt_r < EW'(MAX_EDGES));
  assign sts.src_done  = (s_r >= n_eff);
  assign sts.visited_q = vis_q;
  assign sts.onstk_q   = on_q;
  assign sts.cur_zero  = (top_cur_r == '0);
  assign sts.depth_one = (depth_r == DW'(1));
  assign sts.dropped   = drop_r;

  always_comb begin
    cnt_nxt     = cnt_r;
    drop_nxt    = drop_r;
    clr_nxt     = clr_r;
    s_nxt       = s_r;
    depth_nxt   = depth_r;
    top_v_nxt   = top_v_r;
    top_cur_nxt = top_cur_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    t_nxt       = t_r;
    head_we = 1'b0; head_wa = src_r; head_wd = '0; head_ra = s_r[VW-1:0];
    vis_we  = 1'b0; vis_wa  = s_r[VW-1:0]; vis_wd = 1'b0; vis_ra = s_r[VW-1:0];
    on_we   = 1'b0; on_wa   = s_r[VW-1:0]; on_wd  = 1'b0; on_ra  = etgt_q;
    pool_we = 1'b0; pool_wa = cnt_r[EIW-1:0];
    pool_ra = EIW'(top_cur_r - EW'(1));
    stk_we  = 1'b0; stk_wa  = VW'(depth_r - DW'(1)); stk_ra = VW'(depth_r - DW'(2));
    unique case (op)
      dgcd_pkg::DP_NOP: ;
      dgcd_pkg::DP_CLR: begin
        head_we = 1'b1; head_wa = clr_r; head_wd = '0;
        vis_we  = 1'b1; vis_wa  = clr_r; vis_wd  = 1'b0;
        on_we   = 1'b1; on_wa   = clr_r; on_wd   = 1'b0;
        clr_nxt = clr_r + VW'(1);
      end
      dgcd_pkg::DP_ADD_RD: begin
        head_ra = VW'(in_source_vertex);
        src_nxt = VW'(in_source_vertex);
        dst_nxt = VW'(in_target_vertex);
      end
      dgcd_pkg::DP_ADD_WR: begin
        pool_we = 1'b1;
        head_we = 1'b1; head_wa = src_r; head_wd = cnt_r + EW'(1);
        cnt_nxt = cnt_r + EW'(1);
      end
      dgcd_pkg::DP_DROP: drop_nxt = 1'b1;
      dgcd_pkg::DP_CHK_INIT: begin
        s_nxt     = '0;
        depth_nxt = '0;
      end
      dgcd_pkg::DP_START_RD: vis_ra = s_r[VW-1:0];
      dgcd_pkg::DP_START_PUSH: begin
        vis_we = 1'b1; vis_wa = s_r[VW-1:0]; vis_wd = 1'b1;
        on_we  = 1'b1; on_wa  = s_r[VW-1:0]; on_wd  = 1'b1;
        head_ra   = s_r[VW-1:0];
        top_v_nxt = s_r[VW-1:0];
        depth_nxt = '0;
      end
      dgcd_pkg::DP_NEXT_SRC: s_nxt = s_r + CW'(1);
      dgcd_pkg::DP_PUSH_LD: begin
        top_cur_nxt = head_q;
        depth_nxt   = depth_r + DW'(1);
      end
      dgcd_pkg::DP_POP: begin
        on_we = 1'b1; on_wa = top_v_r; on_wd = 1'b0;
        depth_nxt = depth_r - DW'(1);
        // last frame popped: move on to the next start vertex
        if (depth_r == DW'(1)) begin
          s_nxt = s_r + CW'(1);
        end
      end
      dgcd_pkg::DP_POP_LD: begin
        top_v_nxt   = stk_q[SW-1:EW];
        top_cur_nxt = stk_q[EW-1:0];
      end
      dgcd_pkg::DP_EDGE_RD: pool_ra = EIW'(top_cur_r - EW'(1));
      dgcd_pkg::DP_EDGE_LD: begin
        t_nxt       = etgt_q;
        top_cur_nxt = enxt_q;
        on_ra       = etgt_q;
        vis_ra      = etgt_q;
      end
      dgcd_pkg::DP_EDGE_PUSH: begin
        stk_we = 1'b1; stk_wa = VW'(depth_r - DW'(1));
        vis_we = 1'b1; vis_wa = t_r; vis_wd = 1'b1;
        on_we  = 1'b1; on_wa  = t_r; on_wd  = 1'b1;
        head_ra   = t_r;
        top_v_nxt = t_r;
      end
      dgcd_pkg::DP_RESULT: begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
        clr_nxt  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 11'd1024;
      cnt_r    <= '0;
      drop_r   <= 1'b0;
      clr_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_vertex_count;
      end
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
      clr_r  <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r       <= s_nxt;
    depth_r   <= depth_nxt;
    top_v_r   <= top_v_nxt;
    top_cur_r <= top_cur_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    t_r       <= t_nxt;
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (on_we) begin
      on_mem[on_wa] <= on_wd;
    end
    on_q <= on_mem[on_ra];
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      etgt_mem[pool_wa] <= dst_r;
      enxt_mem[pool_wa] <= head_q;
    end
    etgt_q <= etgt_mem[pool_ra];
    enxt_q <= enxt_mem[pool_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= {top_v_r, top_cur_r};
    end
    stk_q <= stk_mem[stk_ra];
  end

endmodule

// ----- design/dgcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// dgcd_ctrl: sequencer for edge loading, the walk and the clearing sweep
// Drives datapath commands, the input stall and the result register.
// ----------------------------------------------------------------------------
module dgcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_has_cycle,
  output logic              out_input_error,
  input  dgcd_pkg::sts_t    sts,
  output dgcd_pkg::dp_op_t  op
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ADD_W, ST_START, ST_START_W, ST_PUSH_W,
    ST_WALK, ST_POP_W, ST_EDGE_W, ST_EDGE_C, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   found_r, found_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   has_cycle_r, has_cycle_nxt;
  logic   in_err_r, in_err_nxt;

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_has_cycle   = has_cycle_r;
  assign out_input_error = in_err_r;

  always_comb begin
    state_nxt     = state_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;
    has_cycle_nxt = has_cycle_r;
    in_err_nxt    = in_err_r;
    op            = dgcd_pkg::DP_NOP;
    unique case (state_r)
      ST_CLEAR: begin
        op = dgcd_pkg::DP_CLR;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op) begin
            op        = dgcd_pkg::DP_CHK_INIT;
            found_nxt = 1'b0;
            state_nxt = ST_START;
          end else if (sts.edge_ok) begin
            op        = dgcd_pkg::DP_ADD_RD;
            state_nxt = ST_ADD_W;
          end else begin
            op = dgcd_pkg::DP_DROP;
          end
        end
      end
      ST_ADD_W: begin
        op        = dgcd_pkg::DP_ADD_WR;
        state_nxt = ST_IDLE;
      end
      ST_START: begin
        if (sts.src_done) begin
          state_nxt = ST_DONE;
        end else begin
          op        = dgcd_pkg::DP_START_RD;
          state_nxt = ST_START_W;
        end
      end
      ST_START_W: begin
        if (sts.visited_q) begin
          op        = dgcd_pkg::DP_NEXT_SRC;
          state_nxt = ST_START;
        end else begin
          op        = dgcd_pkg::DP_START_PUSH;
          state_nxt = ST_PUSH_W;
        end
      end
      ST_PUSH_W: begin
        op        = dgcd_pkg::DP_PUSH_LD;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.cur_zero) begin
          op        = dgcd_pkg::DP_POP;
          state_nxt = sts.depth_one ? ST_START : ST_POP_W;
        end else begin
          op        = dgcd_pkg::DP_EDGE_RD;
          state_nxt = ST_EDGE_W;
        end
      end
      ST_POP_W: begin
        op        = dgcd_pkg::DP_POP_LD;
        state_nxt = ST_WALK;
      end
      ST_EDGE_W: begin
        op        = dgcd_pkg::DP_EDGE_LD;
        state_nxt = ST_EDGE_C;
      end
      ST_EDGE_C: begin
        if (sts.onstk_q) begin
          // back edge to the live path
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (!sts.visited_q) begin
          op        = dgcd_pkg::DP_EDGE_PUSH;
          state_nxt = ST_PUSH_W;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          op            = dgcd_pkg::DP_RESULT;
          out_valid_nxt = 1'b1;
          has_cycle_nxt = found_r;
          in_err_nxt    = sts.dropped;
          state_nxt     = ST_CLEAR;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    has_cycle_r <= has_cycle_nxt;
    in_err_r    <= in_err_nxt;
  end

endmodule

// ----- design/dgcd_checker.sv -----
// ----------------------------------------------------------------------------
// dgcd_checker: port-level checks for the cycle detector
// Watches handshakes and the check sequencing on the top level ports.
// ----------------------------------------------------------------------------
module dgcd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_op,
  input logic out_valid,
  input logic out_stall,
  input logic out_has_cycle
);

  // a check beat holds off the next input while the walk runs
  a_check_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op |=> in_stall)
    else $error("input not stalled after check beat");

  // a new result shows up only while the clearing sweep holds off input
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_stall)
    else $error("result raised while input open");

  // clearing sweep after reset blocks input
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_has_cycle))
    else $error("stalled result dropped or changed");

endmodule

bind directed_graph_cycle_detect_core dgcd_checker u_dgcd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_has_cycle (out_has_cycle)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for directed_graph_cycle_detect_core
// Loads edge beats and check beats and predicts each check result from a local
// adjacency-list graph walk. Covers several vertex counts, dropped edges and
// long back pressure on the result side.
// ----------------------------------------------------------------------------
module tb;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_CHECK    = 1'b1;
  localparam int   NUM_VERTS   = 1024;
  localparam int   NUM_EDGES   = 4096;
  localparam int   SETTLE      = 1300;    // clearing sweep plus margin
  localparam int   IDLE_LIMIT  = 200000;

  typedef struct packed {
    logic has_cycle;
    logic input_error;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [9:0]  in_source_vertex = '0;
  logic [9:0]  in_target_vertex = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_has_cycle;
  logic        out_input_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_vertex_count = 11'd1024;

  directed_graph_cycle_detect_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_source_vertex(in_source_vertex), .in_target_vertex(in_target_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_has_cycle(out_has_cycle), .out_input_error(out_input_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_vertex_count(cfg_vertex_count)
  );

  always #1 clk = ~clk;

  // local copy of the graph
  int          list_head [NUM_VERTS];
  int          edge_dst [NUM_EDGES];
  int          edge_link [NUM_EDGES];
  int          edge_total;
  bit          edge_dropped;
  int          verts_used = 1024;

  verdict_t    verdict_q[$];
  int          errors, edges_sent, checks_sent, results_seen, cycles_seen;
  bit          no_idle;
  bit          hold_req;
  int          hold_cnt;
  int          idle_cycles;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int live_count();
    return (verts_used > NUM_VERTS) ? NUM_VERTS : verts_used;
  endfunction

  function automatic void wipe_graph();
    foreach (list_head[i]) list_head[i] = 0;
    edge_total = 0;
    edge_dropped = 0;
  endfunction

  function automatic void store_edge(int src, int dst);
    if (src >= live_count() || dst >= live_count() || edge_total >= NUM_EDGES) begin
      edge_dropped = 1;
    end else begin
      edge_dst[edge_total] = dst;
      edge_link[edge_total] = list_head[src];
      list_head[src] = edge_total + 1;
      edge_total++;
    end
  endfunction

  // iterative DFS, one shared visited set
  function automatic bit walk_finds_loop();
    bit vis [NUM_VERTS];
    bit onst [NUM_VERTS];
    int stk_v [NUM_VERTS];
    int stk_c [NUM_VERTS];
    int depth, top, link, e, t;
    for (int s = 0; s < live_count(); s++) begin
      if (vis[s]) continue;
      vis[s] = 1; onst[s] = 1;
      stk_v[0] = s; stk_c[0] = list_head[s]; depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        link = stk_c[top];
        if (link == 0) begin
          onst[stk_v[top]] = 0;
          depth--;
        end else begin
          e = link - 1;
          t = edge_dst[e];
          stk_c[top] = edge_link[e];
          if (onst[t]) return 1;
          if (!vis[t]) begin
            vis[t] = 1; onst[t] = 1;
            stk_v[depth] = t; stk_c[depth] = list_head[t]; depth++;
          end
        end
      end
    end
    return 0;
  endfunction

  task automatic send_beat(logic op, int src, int dst);
    int gap;
    verdict_t v;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_source_vertex <= src[9:0];
    in_target_vertex <= dst[9:0];
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    if (op == OP_ADD_EDGE) begin
      store_edge(src & 10'h3FF, dst & 10'h3FF);
      edges_sent++;
    end else begin
      v.has_cycle = walk_finds_loop();
      v.input_error = edge_dropped;
      verdict_q.insert(verdict_q.size(), v);
      wipe_graph();
      checks_sent++;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_vertex_count(int n);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_vertex_count <= n[10:0];
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    verts_used = n;
  endtask

  task automatic test_directed();
    set_vertex_count(1024);
    send_beat(OP_ADD_EDGE, 0, 0);          // self-loop
    send_beat(OP_CHECK, 0, 0);
    send_beat(OP_ADD_EDGE, 1023, 0);
    send_beat(OP_ADD_EDGE, 0, 1023);
    send_beat(OP_CHECK, 1023, 1023);
    send_beat(OP_ADD_EDGE, 0, 1);
    send_beat(OP_ADD_EDGE, 1, 2);
    send_beat(OP_ADD_EDGE, 0, 2);
    send_beat(OP_CHECK, 0, 0);
    set_vertex_count(3);
    send_beat(OP_ADD_EDGE, 5, 1);          // out of range source
    send_beat(OP_ADD_EDGE, 0, 2);
    send_beat(OP_ADD_EDGE, 2, 3);          // out of range target
    send_beat(OP_CHECK, 0, 0);
    set_vertex_count(0);
    send_beat(OP_ADD_EDGE, 0, 0);
    send_beat(OP_CHECK, 0, 0);
    set_vertex_count(1);
    send_beat(OP_ADD_EDGE, 0, 0);
    send_beat(OP_CHECK, 0, 0);
    set_vertex_count(2047);                // clamps to capacity
    send_beat(OP_ADD_EDGE, 1023, 1023);
    send_beat(OP_CHECK, 0, 0);
    // count lowered after loading: loop unreachable from the live range
    set_vertex_count(8);
    send_beat(OP_ADD_EDGE, 5, 6);
    send_beat(OP_ADD_EDGE, 6, 5);
    set_vertex_count(4);
    send_beat(OP_CHECK, 0, 0);
    // ...and reachable through a live vertex
    set_vertex_count(8);
    send_beat(OP_ADD_EDGE, 0, 5);
    send_beat(OP_ADD_EDGE, 5, 6);
    send_beat(OP_ADD_EDGE, 6, 5);
    set_vertex_count(2);
    send_beat(OP_CHECK, 0, 0);
  endtask

  task automatic random_graph(int span, bit noisy);
    int k, a, b;
    k = $urandom_range(1, 14);
    for (int i = 0; i < k; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
      end else begin
        a = $urandom_range(0, span - 1);
        b = $urandom_range(0, span - 1);
        // mostly forward edges so acyclic graphs show up too
        if ($urandom_range(0, 3) != 0 && a > b) begin
          a = a ^ b; b = a ^ b; a = a ^ b;
        end
        if (a == b && $urandom_range(0, 3) != 0) b = (a + 1) % span;
      end
      send_beat(OP_ADD_EDGE, a, b);
    end
    send_beat(OP_CHECK, $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  task automatic test_random();
    int counts [8] = '{1, 2, 3, 5, 9, 16, 64, 1024};
    int start, n;
    start = edges_sent + checks_sent;
    while (edges_sent + checks_sent - start < 970) begin
      if ($urandom_range(0, 2) == 0) n = $urandom_range(1, 2047);
      else n = counts[$urandom_range(0, 7)];
      set_vertex_count(n);
      no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(4, 12))
        random_graph((n > 24 || n == 0) ? 24 : n, 1'b1);
      no_idle = 0;
    end
  endtask

  task automatic test_back_pressure();
    set_vertex_count(16);
    hold_req = 1;
    repeat (6) random_graph(16, 1'b0);
  endtask

  // result side: random stall, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = 3000;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 30);
    end
  end

  // result checker and watchdog, sampled mid-cycle
  always @(negedge clk) begin
    verdict_t v;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          v = verdict_q.pop_front();
          if (out_has_cycle !== v.has_cycle) begin
            $error("has_cycle: expected %0b actual %0b", v.has_cycle, out_has_cycle);
            errors++;
          end
          if (out_input_error !== v.input_error) begin
            $error("input_error: expected %0b actual %0b", v.input_error, out_input_error);
            errors++;
          end
          if (v.has_cycle) cycles_seen++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("directed_graph_cycle_detect_core test failed");
        $finish;
      end
    end
  end

  initial begin
    wipe_graph();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_back_pressure();
    test_random();
    drain_results();
    $display("Covered %0d edge beats and %0d checks; %0d results, %0d with a cycle.",
             edges_sent, checks_sent, results_seen, cycles_seen);
    if (errors == 0) begin
      $display("directed_graph_cycle_detect_core test passed");
    end else begin
      $display("directed_graph_cycle_detect_core test failed");
    end
    $finish;
  end

endmodule
